// ----- hdl/ahgl_pkg.sv -----
// shared types, constants and helper functions of the high-pass gain limiter
package ahgl_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DUTY_W   = 12;
	localparam int VOL_W    = 10;
	localparam int YMAG_W   = 23;
	localparam int PROD_W   = YMAG_W + VOL_W;
	localparam int QUOT_W   = 27;
	localparam int REM_W    = 7;

	localparam logic [VOL_W-1:0]    VolMax    = 10'd800;
	localparam logic [REM_W:0]      Divisor   = 8'd100;
	localparam logic [QUOT_W-1:0]   MagMax    = 27'd32767;

	typedef struct packed {
		logic [YMAG_W-1:0] mag;
		logic              neg;
	} filt_res_t;

	typedef struct packed {
		logic [DUTY_W-1:0]          duty;
		logic signed [SAMPLE_W-1:0] sample;
	} lim_res_t;

	function automatic logic [QUOT_W-1:0] knee_val(input logic [1:0] idx);
		logic [QUOT_W-1:0] v;
		unique case (idx)
			2'd0: v = 27'd20000;
			2'd1: v = 27'd26000;
			2'd2: v = 27'd30000;
			2'd3: v = 27'd32000;
			default: v = 27'd32000;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] knee_shift(input logic [1:0] idx);
		return (idx == 2'd3) ? 2'd2 : 2'd1;
	endfunction

	function automatic logic [DUTY_W-1:0] duty_of(input logic [SAMPLE_W-1:0] s);
		return {~s[SAMPLE_W-1], s[SAMPLE_W-2:SAMPLE_W-DUTY_W]};
	endfunction

endpackage

// ----- hdl/audio_highpass_gain_soft_limiter.sv -----
// top level of the high-pass, gain and soft-knee limiter with pwm duty output
//
// channel   signals                              transfer when
// input     in_valid in_ready left/right_sample  in_valid && in_ready
// output    out_valid out_ready duty limited     out_valid && out_ready
// gain      gain_pct_we gain_pct                 gain_pct_we
//
// out_valid rises after 5 filter, 10 multiply, 33 divide and 6 limiter steps,
// with a registered hand-off after each unit
// in_ready is high only while no item is in the core, so a new item enters only after the last one has left;
// a finished result waits in the output register, and the next item may enter meanwhile
// a result that finds the output register full holds the core until taken
// arst_n clears control state, the gain and the filter history
module audio_highpass_gain_soft_limiter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ahgl_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [ahgl_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ahgl_pkg::DUTY_W-1:0]         duty,
	output logic signed [ahgl_pkg::SAMPLE_W-1:0] limited_sample,
	input  logic                                gain_pct_we,
	input  logic [ahgl_pkg::VOL_W-1:0]          gain_pct
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_HOLD
	} state_t;

	state_t                         state_q;
	logic [ahgl_pkg::VOL_W-1:0]     vol_q;
	logic                           neg_q;
	logic                           out_valid_q;
	ahgl_pkg::lim_res_t             out_q;

	logic                           in_xfer;
	logic                           filt_done;
	logic                           mul_done;
	logic                           div_done;
	logic                           lim_done;
	ahgl_pkg::filt_res_t            filt_res;
	logic [ahgl_pkg::PROD_W-1:0]    prod;
	logic [ahgl_pkg::QUOT_W-1:0]    quot;
	ahgl_pkg::lim_res_t             lim_res;
	logic                           out_free;
	logic                           out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && (((state_q == ST_BUSY) && lim_done) || (state_q == ST_HOLD));

	ahgl_filter u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_xfer),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.done         (filt_done),
		.res          (filt_res)
	);

	ahgl_mul_serial u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (filt_done),
		.a      (filt_res.mag),
		.b      (vol_q),
		.done   (mul_done),
		.prod   (prod)
	);

	ahgl_div_serial u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_done),
		.dividend (prod),
		.done     (div_done),
		.quot     (quot)
	);

	ahgl_limiter u_limiter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_done),
		.mag    (quot),
		.neg    (neg_q),
		.done   (lim_done),
		.res    (lim_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= '0;
		end else if (gain_pct_we) begin
			vol_q <= (gain_pct > ahgl_pkg::VolMax) ? ahgl_pkg::VolMax : gain_pct;
		end
	end

	always_ff @(posedge clk) begin
		if (filt_done) begin
			neg_q <= filt_res.neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_q       <= lim_res;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (lim_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign duty           = out_q.duty;
	assign limited_sample = out_q.sample;

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken while an item is in the core");

	a_no_min_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (limited_sample != 16'sh8000))
		else $error("limited sample outside symmetric range");

	a_duty_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty == {~limited_sample[15], limited_sample[14:4]}))
		else $error("duty does not follow limited sample");

	a_mute: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (vol_q == '0)) |-> (limited_sample == 16'sd0))
		else $error("non-silent result at zero gain");

endmodule

// ----- hdl/ahgl_filter.sv -----
// mono downmix and one-pole high-pass, stepped over five steps
module ahgl_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [ahgl_pkg::SAMPLE_W-1:0]  left_sample,
	input  logic signed [ahgl_pkg::SAMPLE_W-1:0]  right_sample,
	output logic                                  done,
	output ahgl_pkg::filt_res_t                   res
);

	logic                 busy_q;
	logic                 done_q;
	logic [2:0]           cnt_q;
	logic [16:0]          sum_q;
	logic [15:0]          x_q;
	logic [23:0]          d_q;
	logic [31:0]          t_q;
	logic [23:0]          y_q;
	logic [15:0]          prev_x_q;
	logic [21:0]          prev_y_q;
	ahgl_pkg::filt_res_t  res_q;

	logic [16:0]          sum_adj;
	logic [31:0]          p_full;

	assign sum_adj = sum_q + {16'd0, sum_q[16] & sum_q[0]};
	assign p_full  = t_q - {{7{d_q[23]}}, d_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sum_q  <= {left_sample[15], left_sample} + {right_sample[15], right_sample};
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				unique case (cnt_q)
					3'd0: x_q <= sum_adj[16:1];
					3'd1: begin
						d_q <= {{2{prev_y_q[21]}}, prev_y_q} + {{8{x_q[15]}}, x_q}
							- {{8{prev_x_q[15]}}, prev_x_q};
						prev_x_q <= x_q;
					end
					3'd2: t_q <= {d_q, 8'd0} - {{5{d_q[23]}}, d_q, 3'd0};
					3'd3: begin
						y_q      <= p_full[31:8];
						prev_y_q <= p_full[29:8];
					end
					default: begin
						res_q.neg <= y_q[23];
						res_q.mag <= y_q[23] ? 23'(24'd0 - y_q) : y_q[22:0];
						busy_q    <= 1'b0;
						done_q    <= 1'b1;
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- hdl/ahgl_mul_serial.sv -----
// shift-add multiplier, one volume bit per cycle
module ahgl_mul_serial (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ahgl_pkg::YMAG_W-1:0]         a,
	input  logic [ahgl_pkg::VOL_W-1:0]          b,
	output logic                                done,
	output logic [ahgl_pkg::PROD_W-1:0]         prod
);

	localparam logic [3:0] LastStep = 4'(ahgl_pkg::VOL_W - 1);

	logic                           busy_q;
	logic                           done_q;
	logic [3:0]                     cnt_q;
	logic [ahgl_pkg::PROD_W-1:0]    a_q;
	logic [ahgl_pkg::VOL_W-1:0]     b_q;
	logic [ahgl_pkg::PROD_W-1:0]    acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= {{(ahgl_pkg::PROD_W - ahgl_pkg::YMAG_W){1'b0}}, a};
				b_q    <= b;
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q   <= {a_q[ahgl_pkg::PROD_W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[ahgl_pkg::VOL_W-1:1]};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- hdl/ahgl_div_serial.sv -----
// restoring division by one hundred, one quotient bit per cycle
module ahgl_div_serial (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ahgl_pkg::PROD_W-1:0]         dividend,
	output logic                                done,
	output logic [ahgl_pkg::QUOT_W-1:0]         quot
);

	localparam logic [5:0] LastStep = 6'(ahgl_pkg::PROD_W - 1);

	logic                           busy_q;
	logic                           done_q;
	logic [5:0]                     cnt_q;
	logic [ahgl_pkg::PROD_W-1:0]    r_q;
	logic [ahgl_pkg::REM_W-1:0]     rem_q;

	logic [ahgl_pkg::REM_W:0]       trial;
	logic [ahgl_pkg::REM_W:0]       diff;
	logic                           ge;

	assign trial = {rem_q, r_q[ahgl_pkg::PROD_W-1]};
	assign ge    = (trial >= ahgl_pkg::Divisor);
	assign diff  = trial - ahgl_pkg::Divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				r_q    <= dividend;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[ahgl_pkg::REM_W-1:0] : trial[ahgl_pkg::REM_W-1:0];
				r_q   <= {r_q[ahgl_pkg::PROD_W-2:0], ge};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = r_q[ahgl_pkg::QUOT_W-1:0];

endmodule

// ----- hdl/ahgl_limiter.sv -----
// soft-knee limiter, one knee per cycle, then clamp, sign and duty
module ahgl_limiter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ahgl_pkg::QUOT_W-1:0]         mag,
	input  logic                                neg,
	output logic                                done,
	output ahgl_pkg::lim_res_t                  res
);

	logic                           busy_q;
	logic                           done_q;
	logic [2:0]                     cnt_q;
	logic [ahgl_pkg::QUOT_W-1:0]    mag_q;
	logic                           neg_q;
	ahgl_pkg::lim_res_t             res_q;

	logic [ahgl_pkg::QUOT_W-1:0]    knee;
	logic [ahgl_pkg::QUOT_W-1:0]    over;
	logic [ahgl_pkg::SAMPLE_W-1:0]  s_val;

	assign knee  = ahgl_pkg::knee_val(cnt_q[1:0]);
	assign over  = (mag_q - knee) >> ahgl_pkg::knee_shift(cnt_q[1:0]);
	assign s_val = neg_q ? (16'd0 - mag_q[15:0]) : mag_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mag_q  <= mag;
				neg_q  <= neg;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				priority if (!cnt_q[2]) begin
					if (mag_q > knee) begin
						mag_q <= knee + over;
					end
				end else if (cnt_q == 3'd4) begin
					if (mag_q > ahgl_pkg::MagMax) begin
						mag_q <= ahgl_pkg::MagMax;
					end
				end else begin
					res_q.sample <= s_val;
					res_q.duty   <= ahgl_pkg::duty_of(s_val);
					busy_q       <= 1'b0;
					done_q       <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- sim/tb_audio_highpass_gain_soft_limiter.sv -----
// self-checking testbench for the high-pass, gain and soft-knee limiter block
module tb_audio_highpass_gain_soft_limiter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 300;
	localparam int REPORT_MAX    = 10;
	localparam int PHASES        = 8;
	localparam int PHASE_PAIRS   = 75;

	localparam longint HP_COEF    = 246;
	localparam longint GAIN_DIV   = 100;
	localparam longint KNEE1      = 20000;
	localparam longint KNEE2      = 26000;
	localparam longint KNEE3      = 30000;
	localparam longint KNEE4      = 32000;
	localparam longint MAG_LIMIT  = 32767;
	localparam longint MID_OFFSET = 32768;

	localparam logic signed [ahgl_pkg::SAMPLE_W-1:0] FULL_POS = 16'sh7fff;
	localparam logic signed [ahgl_pkg::SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

	typedef enum {FULL_RANDOM, SMALL_SWING, SQUARE_WAVE, HOLD_LEVEL, ONE_RAIL} pair_kind_t;

	class limiter_scoreboard_t;
		logic [ahgl_pkg::VOL_W-1:0]           volume;
		logic signed [ahgl_pkg::SAMPLE_W-1:0] prev_mono;
		logic signed [21:0]                   prev_filt;
		ahgl_pkg::lim_res_t                   pending_outputs[$];
		int unsigned                          errors;

		function new();
			volume    = '0;
			prev_mono = '0;
			prev_filt = '0;
			errors    = 0;
		endfunction

		function void set_volume(logic [ahgl_pkg::VOL_W-1:0] v);
			volume = (v > ahgl_pkg::VolMax) ? ahgl_pkg::VolMax : v;
		endfunction

		function void take_pair(logic signed [ahgl_pkg::SAMPLE_W-1:0] l,
			logic signed [ahgl_pkg::SAMPLE_W-1:0] r);
			longint             x, y, s, mag, off;
			ahgl_pkg::lim_res_t res;
			x = (longint'(l) + longint'(r)) / 2;
			y = ((longint'(prev_filt) + x - longint'(prev_mono)) * HP_COEF) >>> 8;
			prev_mono = x[ahgl_pkg::SAMPLE_W-1:0];
			prev_filt = y[21:0];
			s = (y * longint'(volume)) / GAIN_DIV;
			mag = (s < 0) ? -s : s;
			if (mag > KNEE1) begin
				mag = KNEE1 + ((mag - KNEE1) >>> 1);
			end
			if (mag > KNEE2) begin
				mag = KNEE2 + ((mag - KNEE2) >>> 1);
			end
			if (mag > KNEE3) begin
				mag = KNEE3 + ((mag - KNEE3) >>> 1);
			end
			if (mag > KNEE4) begin
				mag = KNEE4 + ((mag - KNEE4) >>> 2);
			end
			if (mag > MAG_LIMIT) begin
				mag = MAG_LIMIT;
			end
			s = (s < 0) ? -mag : mag;
			off = s + MID_OFFSET;
			res.duty   = off[15:4];
			res.sample = s[ahgl_pkg::SAMPLE_W-1:0];
			pending_outputs.push_back(res);
		endfunction

		function void check_output(logic [ahgl_pkg::DUTY_W-1:0] d,
			logic signed [ahgl_pkg::SAMPLE_W-1:0] smp);
			ahgl_pkg::lim_res_t want;
			if (pending_outputs.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("unexpected output: duty %0d sample %0d", d, smp);
				end
				return;
			end
			want = pending_outputs.pop_front();
			if (d !== want.duty || smp !== want.sample) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("output mismatch: duty expected %0d got %0d, sample expected %0d got %0d",
						want.duty, d, want.sample, smp);
				end
			end
		endfunction
	endclass

	logic                                 clk            = 1'b0;
	logic                                 arst_n         = 1'b0;
	logic                                 in_valid       = 1'b0;
	logic                                 in_ready;
	logic signed [ahgl_pkg::SAMPLE_W-1:0] left_sample    = '0;
	logic signed [ahgl_pkg::SAMPLE_W-1:0] right_sample   = '0;
	logic                                 out_valid;
	logic                                 out_ready      = 1'b0;
	logic [ahgl_pkg::DUTY_W-1:0]          duty;
	logic signed [ahgl_pkg::SAMPLE_W-1:0] limited_sample;
	logic                                 gain_pct_we    = 1'b0;
	logic [ahgl_pkg::VOL_W-1:0]           gain_pct       = '0;

	int          send_idle     = 0;
	int          recv_stall    = 0;
	int          hold_requests = 0;
	int          hold_served   = 0;
	int          hold_left     = 0;
	int unsigned cycle_count   = 0;

	limiter_scoreboard_t sb;

	audio_highpass_gain_soft_limiter DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.duty           (duty),
		.limited_sample (limited_sample),
		.gain_pct_we    (gain_pct_we),
		.gain_pct       (gain_pct)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off counted here on request
	always @(negedge clk) begin
		if (hold_left == 0 && hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && out_valid && out_ready) begin
			sb.check_output(duty, limited_sample);
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_pair(input logic signed [ahgl_pkg::SAMPLE_W-1:0] l,
		input logic signed [ahgl_pkg::SAMPLE_W-1:0] r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		left_sample  = l;
		right_sample = r;
		do @(posedge clk); while (!in_ready);
		sb.take_pair(l, r);
	endtask

	task automatic write_volume(input logic [ahgl_pkg::VOL_W-1:0] v);
		@(negedge clk);
		gain_pct_we = 1'b1;
		gain_pct    = v;
		@(negedge clk);
		gain_pct_we = 1'b0;
		sb.set_volume(v);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_pairs(input int n);
		pair_kind_t                           kind;
		int                                   pick;
		int                                   burst;
		logic                                 sq;
		logic signed [ahgl_pkg::SAMPLE_W-1:0] l;
		logic signed [ahgl_pkg::SAMPLE_W-1:0] r;
		kind  = FULL_RANDOM;
		burst = 0;
		sq    = 1'b0;
		l     = '0;
		r     = '0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				pick  = $urandom_range(9);
				kind  = (pick < 4) ? FULL_RANDOM : (pick < 6) ? SMALL_SWING :
					(pick < 8) ? SQUARE_WAVE : (pick < 9) ? HOLD_LEVEL : ONE_RAIL;
				burst = $urandom_range(1, 12);
			end
			burst--;
			case (kind)
				FULL_RANDOM: begin
					l = 16'($urandom);
					r = 16'($urandom);
				end
				SMALL_SWING: begin
					l = 16'($urandom_range(511) - 256);
					r = 16'($urandom_range(511) - 256);
				end
				SQUARE_WAVE: begin
					sq = ~sq;
					l  = sq ? FULL_POS : FULL_NEG;
					r  = l ^ 16'($urandom_range(1023));
				end
				HOLD_LEVEL: begin
				end
				default: begin
					l = $urandom_range(1) ? FULL_POS : FULL_NEG;
					r = 16'($urandom);
				end
			endcase
			send_pair(l, r);
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// gain still at its reset value: silence while the filter runs
		send_pair(FULL_POS, FULL_POS);
		send_pair(FULL_NEG, FULL_NEG);
		send_pair(16'sd0, 16'sd0);
		send_pair(-16'sd1, 16'sd0);
		send_pair(16'sd1, 16'sd0);
		wait_idle();

		// saturating write, then full-scale square wave to push filter and limiter
		write_volume(10'd1023);
		for (int i = 0; i < 10; i++) begin
			send_pair(i[0] ? FULL_NEG : FULL_POS, i[0] ? FULL_NEG : FULL_POS);
		end
		send_pair(FULL_NEG, FULL_POS);
		send_pair(-16'sd3, 16'sd0);
		send_pair(16'sd3, 16'sd0);
		send_pair(16'sd0, 16'sd0);
		send_pair(16'sd0, 16'sd0);
		send_pair(16'sd0, 16'sd0);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_volume(10'd100);
				1: write_volume(10'd800);
				2: write_volume(10'd801);
				3: write_volume(10'd0);
				4: write_volume(10'd1);
				5: write_volume(10'd799);
				6: write_volume(10'($urandom_range(1023)));
				default: write_volume(10'($urandom_range(300, 800)));
			endcase
			send_idle  = (p % 4 == 1) ? 75 : (p % 4 == 3) ? 13 : 0;
			recv_stall = (p % 4 == 2) ? 75 : (p % 4 == 3) ? 13 : 0;
			if (p == 4) begin
				hold_requests++;
			end
			random_pairs(PHASE_PAIRS);
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
